[sv/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg
// shared types and constants for the calendar date sorter
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned MAX_DATES_DEF = 64;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned KEY_W   = DAY_W + MONTH_W + YEAR_W;

  localparam int unsigned DAY_LSB   = 0;
  localparam int unsigned MONTH_LSB = DAY_LSB + DAY_W;
  localparam int unsigned YEAR_LSB  = MONTH_LSB + MONTH_W;

  // year, month, day from msb to lsb, so a plain compare orders dates
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               batch_end;
  } date_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   sorted_day;
    logic [MONTH_W-1:0] sorted_month;
    logic [YEAR_W-1:0]  sorted_year;
    logic               final_result;
    logic               overflow;
  } date_out_t;

  typedef struct packed {
    logic wr_en;
    logic wr_load;
    logic rd_en;
    logic rd_first;
    logic out_load;
    logic out_final;
    logic out_ovf;
  } cds_cmd_t;

endpackage

[sv/calendar_date_sorter.sv]
// ----------------------------------------------------------------------------
// calendar_date_sorter
// collects a batch of dates and returns them in ascending date order
// ----------------------------------------------------------------------------
// Dates load one per cycle into a MaxDates-entry memory; dates past capacity
// are dropped and every result of that batch carries overflow. After the date
// flagged batch_end the input stalls while the batch is sorted by repeated
// minimum search over the single memory read port: each result takes one
// read per remaining date, a drain and an emit with swap, and the emit waits
// while the output is stalled. The last result carries final_result, and
// loading of the next batch starts in the cycle after it is handed to the
// output register.
module calendar_date_sorter import cds_pkg::*; #(
  parameter int unsigned MaxDates = MAX_DATES_DEF,
  localparam int unsigned IdxW = $clog2(MaxDates)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  date_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output date_out_t out_data_o
);

  cds_cmd_t        cmd;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;
  logic            out_free;

  cds_ctrl #(
    .MaxDates (MaxDates)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.batch_end),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  cds_datapath #(
    .MaxDates (MaxDates)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_addr_i   (rd_addr),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // a batch end transaction starts the sort, so input stalls next cycle
  a_stall_after_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.batch_end |=> in_stall_o)
    else $error("input not stalled after batch end");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // results are only produced while the input side is stalled or just after
  a_emit_while_sorting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced while loading");
`endif

endmodule

[sv/cds_ctrl.sv]
// ----------------------------------------------------------------------------
// cds_ctrl
// load, scan and emit sequencer for the date sorter
// ----------------------------------------------------------------------------
module cds_ctrl import cds_pkg::*; #(
  parameter int unsigned MaxDates = MAX_DATES_DEF,
  localparam int unsigned IdxW = $clog2(MaxDates),
  localparam int unsigned CntW = $clog2(MaxDates + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_stall_o,
  input  logic            out_free_i,
  output cds_cmd_t        cmd_o,
  output logic [IdxW-1:0] wr_addr_o,
  output logic [IdxW-1:0] rd_addr_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            drop_q;
  logic [IdxW-1:0] i_q;
  logic [IdxW-1:0] j_q;
  logic [IdxW-1:0] last_q;

  logic full;
  logic in_acc;

  assign full       = (cnt_q == CntW'(MaxDates));
  assign in_acc     = in_valid_i && (state_q == ST_LOAD);
  assign in_stall_o = (state_q != ST_LOAD);
  assign wr_addr_o  = cnt_q[IdxW-1:0];
  assign rd_addr_o  = j_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.wr_en   = in_acc && !full;
        cmd_o.wr_load = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (j_q == i_q);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.wr_en     = 1'b1;
          cmd_o.out_final = (i_q == last_q);
          cmd_o.out_ovf   = drop_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      last_q  <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              drop_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            if (in_last_i) begin
              last_q  <= full ? IdxW'(MaxDates - 1) : cnt_q[IdxW-1:0];
              i_q     <= '0;
              j_q     <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (j_q == last_q) begin
            state_q <= ST_DRAIN;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free_i) begin
            if (i_q == last_q) begin
              cnt_q   <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              i_q     <= i_q + 1'b1;
              j_q     <= i_q + 1'b1;
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

[sv/cds_datapath.sv]
// ----------------------------------------------------------------------------
// cds_datapath
// date memory, minimum search registers and output register
// ----------------------------------------------------------------------------
module cds_datapath import cds_pkg::*; #(
  parameter int unsigned MaxDates = MAX_DATES_DEF,
  localparam int unsigned IdxW = $clog2(MaxDates)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  date_in_t        in_data_i,
  input  cds_cmd_t        cmd_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic            out_stall_i,
  output logic            out_free_o,
  output logic            out_valid_o,
  output date_out_t       out_data_o
);

  key_t            mem_q [MaxDates];
  key_t            rd_key_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_first_q;
  logic            cmp_v_q;
  key_t            min_key_q;
  logic [IdxW-1:0] min_idx_q;
  key_t            head_key_q;
  logic            out_valid_q;
  date_out_t       out_data_q;

  key_t            in_key;
  key_t            wr_key;
  logic [IdxW-1:0] wr_addr;
  logic            take_min;

  assign in_key   = {in_data_i.year, in_data_i.month, in_data_i.day};
  // swap: head of the unsorted range moves to where the minimum was
  assign wr_key   = cmd_i.wr_load ? in_key : head_key_q;
  assign wr_addr  = cmd_i.wr_load ? wr_addr_i : min_idx_q;
  assign take_min = cmp_v_q && (rd_first_q || (rd_key_q < min_key_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_key;
    end
    if (cmd_i.rd_en) begin
      rd_key_q   <= mem_q[rd_addr_i];
      rd_idx_q   <= rd_addr_i;
      rd_first_q <= cmd_i.rd_first;
    end
    if (take_min) begin
      min_key_q <= rd_key_q;
      min_idx_q <= rd_idx_q;
    end
    if (cmp_v_q && rd_first_q) begin
      head_key_q <= rd_key_q;
    end
    if (cmd_i.out_load) begin
      out_data_q.sorted_day   <= min_key_q[DAY_LSB +: DAY_W];
      out_data_q.sorted_month <= min_key_q[MONTH_LSB +: MONTH_W];
      out_data_q.sorted_year  <= min_key_q[YEAR_LSB +: YEAR_W];
      out_data_q.final_result <= cmd_i.out_final;
      out_data_q.overflow     <= cmd_i.out_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.rd_en;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// ordered date output check for calendar_date_sorter
// ----------------------------------------------------------------------------
// Batches of dates go into the sorter, and a local model sorts the same
// batches by year, then month, then day. Each output transaction is checked
// against the oldest expected date. A short directed table comes first: one
// date batches at the field extremes, unvalidated dates, duplicate dates, and
// presorted and reverse sorted batches. Random batches follow. Most of them
// are small, but there are also a full batch, a batch whose last date is
// dropped, and a batch that overflows. Random gaps and stalls are applied on
// both sides of the sorter.
// ----------------------------------------------------------------------------
module testbench;
  import cds_pkg::*;

  localparam int unsigned CAPACITY = MAX_DATES_DEF;
  localparam int ITEM_GOAL = 320;
  localparam int DIR_N = 23;

  typedef struct packed {
    date_in_t  stim;
    logic      typed;
    date_out_t want;
  } row_t;

  localparam row_t DIR_ROWS [DIR_N] = '{
    {5'd31, 4'd15, 14'd16383, 1'b1, 1'b1, 5'd31, 4'd15, 14'd16383, 1'b1, 1'b0},
    {5'd0,  4'd0,  14'd0,     1'b1, 1'b1, 5'd0,  4'd0,  14'd0,     1'b1, 1'b0},
    {5'd0,  4'd13, 14'd2024,  1'b1, 1'b1, 5'd0,  4'd13, 14'd2024,  1'b1, 1'b0},
    {5'd15, 4'd6,  14'd2000,  1'b0, 1'b0, 25'd0},
    {5'd14, 4'd6,  14'd2000,  1'b0, 1'b0, 25'd0},
    {5'd15, 4'd5,  14'd2000,  1'b0, 1'b0, 25'd0},
    {5'd1,  4'd1,  14'd2001,  1'b0, 1'b0, 25'd0},
    {5'd15, 4'd6,  14'd2000,  1'b0, 1'b0, 25'd0},
    {5'd31, 4'd15, 14'd1999,  1'b0, 1'b0, 25'd0},
    {5'd0,  4'd0,  14'd16383, 1'b1, 1'b0, 25'd0},
    {5'd9,  4'd3,  14'd5000,  1'b0, 1'b0, 25'd0},
    {5'd9,  4'd3,  14'd4000,  1'b0, 1'b0, 25'd0},
    {5'd9,  4'd3,  14'd3000,  1'b0, 1'b0, 25'd0},
    {5'd9,  4'd3,  14'd2000,  1'b0, 1'b0, 25'd0},
    {5'd9,  4'd3,  14'd1000,  1'b1, 1'b0, 25'd0},
    {5'd1,  4'd1,  14'd1,     1'b0, 1'b0, 25'd0},
    {5'd2,  4'd1,  14'd1,     1'b0, 1'b0, 25'd0},
    {5'd1,  4'd2,  14'd1,     1'b0, 1'b0, 25'd0},
    {5'd1,  4'd1,  14'd2,     1'b1, 1'b0, 25'd0},
    {5'd31, 4'd15, 14'd16383, 1'b0, 1'b0, 25'd0},
    {5'd31, 4'd15, 14'd16383, 1'b1, 1'b0, 25'd0},
    {5'd21, 4'd10, 14'h2aaa,  1'b1, 1'b1, 5'd21, 4'd10, 14'h2aaa,  1'b1, 1'b0},
    {5'd10, 4'd5,  14'h1555,  1'b1, 1'b1, 5'd10, 4'd5,  14'h1555,  1'b1, 1'b0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  date_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  date_out_t out_data;

  key_t      batch_keys [$];
  bit        batch_dropped;
  date_out_t pending_dates [$];
  int        mismatches;
  int        in_gap_max;
  int        out_gap_max;
  int        stall_left;
  int        items_sent;

  calendar_date_sorter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic log_mismatch(input string what, input date_out_t want, input date_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected d=%0d m=%0d y=%0d final=%0b ovf=%0b,", what,
               want.sorted_day, want.sorted_month, want.sorted_year,
               want.final_result, want.overflow);
      $display("  got d=%0d m=%0d y=%0d final=%0b ovf=%0b",
               got.sorted_day, got.sorted_month, got.sorted_year,
               got.final_result, got.overflow);
    end
  endtask

  // store the date, and on the last date of a batch sort it and queue the results
  task automatic absorb_date(input date_in_t d, input bit typed, input date_out_t typed_want);
    key_t      k;
    date_out_t r;
    int        i;
    int        j;
    if (batch_keys.size() < CAPACITY) begin
      batch_keys.push_back({d.year, d.month, d.day});
    end else begin
      batch_dropped = 1'b1;
    end
    if (d.batch_end) begin
      for (i = 1; i < batch_keys.size(); i++) begin
        j = i;
        while (j > 0 && batch_keys[j-1] > batch_keys[j]) begin
          k = batch_keys[j];
          batch_keys[j] = batch_keys[j-1];
          batch_keys[j-1] = k;
          j--;
        end
      end
      if (typed) begin
        pending_dates.push_back(typed_want);
      end else begin
        for (i = 0; i < batch_keys.size(); i++) begin
          k = batch_keys[i];
          r.sorted_day   = k[DAY_LSB +: DAY_W];
          r.sorted_month = k[MONTH_LSB +: MONTH_W];
          r.sorted_year  = k[YEAR_LSB +: YEAR_W];
          r.final_result = (i == batch_keys.size() - 1);
          r.overflow     = batch_dropped;
          pending_dates.push_back(r);
        end
      end
      batch_keys.delete();
      batch_dropped = 1'b0;
    end
  endtask

  task automatic send_date(input date_in_t d, input bit typed, input date_out_t typed_want);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (in_stall);
    absorb_date(d, typed, typed_want);
    items_sent++;
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
  endtask

  function automatic date_in_t draw_date();
    date_in_t d;
    d.day   = DAY_W'($urandom_range(0, 31));
    d.month = MONTH_W'($urandom_range(0, 15));
    d.year  = YEAR_W'($urandom_range(0, 16383));
    d.batch_end = 1'b0;
    case ($urandom_range(0, 2))
      1: d.year = YEAR_W'(1999 + $urandom_range(0, 1));
      2: begin
        d.year  = YEAR_W'(2000);
        d.month = MONTH_W'(6);
        d.day   = DAY_W'($urandom_range(14, 16));
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 13;
    endcase
  endfunction

  task automatic send_batch(input int size);
    date_in_t d;
    int       n;
    in_gap_max  = pick_gap_max();
    out_gap_max = pick_gap_max();
    for (n = 0; n < size; n++) begin
      d = draw_date();
      d.batch_end = (n == size - 1);
      send_date(d, 1'b0, '0);
    end
  endtask

  // output side: check each transaction, then draw the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    date_out_t want;
    int        gap;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        log_mismatch("unexpected result", '0, out_data);
      end else begin
        want = pending_dates.pop_front();
        if (out_data.sorted_day != want.sorted_day ||
            out_data.sorted_month != want.sorted_month ||
            out_data.sorted_year != want.sorted_year ||
            out_data.final_result != want.final_result ||
            out_data.overflow != want.overflow) begin
          log_mismatch("wrong result", want, out_data);
        end
      end
      gap = $urandom_range(0, out_gap_max);
      out_stall  <= (gap != 0);
      stall_left <= gap;
    end else if (stall_left > 0) begin
      out_stall  <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    int big_sizes [$];
    int size;
    int i;
    batch_dropped = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    in_gap_max    = 0;
    out_gap_max   = 0;
    big_sizes     = '{64, 65, 67};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      if (i == 10) begin
        in_gap_max  = 13;
        out_gap_max = 13;
      end
      send_date(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    drain_pause();

    while (items_sent < ITEM_GOAL) begin
      if (big_sizes.size() > 0 && $urandom_range(0, 7) == 0) begin
        size = big_sizes.pop_front();
      end else if ($urandom_range(0, 9) == 0) begin
        size = $urandom_range(16, 32);
      end else begin
        size = $urandom_range(1, 8);
      end
      send_batch(size);
      if ($urandom_range(0, 5) == 0) drain_pause();
    end
    while (big_sizes.size() > 0) begin
      send_batch(big_sizes.pop_front());
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_dates.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_dates.size() == 0 && batch_keys.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
